>>> design/stable_priority_queue_top_defines.svh
// ---------------------------------------------------------------------------
// stable_priority_queue_top_defines.svh
// assertion macros used by the checker file
// ---------------------------------------------------------------------------
`ifndef STABLE_PRIORITY_QUEUE_TOP_DEFINES_SVH
`define STABLE_PRIORITY_QUEUE_TOP_DEFINES_SVH

// same-cycle implication, sampled on clk, off while arst_n is low
`define SPQ_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, sampled on clk, off while arst_n is low
`define SPQ_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> design/spq_pkg.sv
// ---------------------------------------------------------------------------
// spq_pkg
// types, codes and defaults shared by the priority queue modules
// ---------------------------------------------------------------------------
package spq_pkg;

	// default number of stored entries
	localparam int QUEUE_DEPTH_DEF = 16;

	localparam int VALUE_W = 32;
	localparam int PRIO_W  = 16;

	// operation codes
	typedef enum logic {
		OP_INSERT = 1'b0,
		OP_REMOVE = 1'b1
	} op_t;

	// result status codes
	typedef enum logic [1:0] {
		STAT_INSERTED = 2'd0,
		STAT_REMOVED  = 2'd1,
		STAT_EMPTY    = 2'd2,
		STAT_FULL     = 2'd3
	} status_t;

	// input item
	typedef struct packed {
		op_t                        operation;
		logic signed [VALUE_W-1:0]  item_value;
		logic signed [PRIO_W-1:0]   item_priority;
	} in_item_t;

	// result item
	typedef struct packed {
		status_t                    status;
		logic signed [VALUE_W-1:0]  removed_value;
	} out_item_t;

	// one stored entry
	typedef struct packed {
		logic signed [PRIO_W-1:0]   prio;
		logic signed [VALUE_W-1:0]  value;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

	// controller states
	typedef enum logic [2:0] {
		S_IDLE,
		S_POP,
		S_SHIFT,
		S_PLACE,
		S_RESP
	} state_t;

	// read address select
	typedef enum logic [1:0] {
		RD_NONE,
		RD_TAIL,
		RD_HEAD,
		RD_BELOW
	} rd_sel_t;

	// write address and data select
	typedef enum logic [2:0] {
		WR_NONE,
		WR_DATA_UP,
		WR_NEW_UP,
		WR_NEW_AT,
		WR_NEW_TAIL
	} wr_sel_t;

	// controller to datapath commands
	typedef struct packed {
		logic    capture;
		rd_sel_t rd_sel;
		wr_sel_t wr_sel;
		logic    cnt_inc;
		logic    pop_head;
		logic    res_set;
		status_t res_status;
		logic    res_take_data;
		logic    out_load;
	} cmd_t;

	// datapath to controller status
	typedef struct packed {
		logic full;
		logic empty;
		logic j_zero;
		logic shift_gt;
		logic out_free;
	} stat_t;

endpackage

>>> design/stable_priority_queue_top.sv
// ---------------------------------------------------------------------------
// stable_priority_queue_top
// minimum-first priority queue, equal priorities leave in arrival order
//
//   channel | handshake          | payload
//   in      | in_valid, in_stall | in_data   (operation, value, priority)
//   out     | out_valid,out_stall| out_data  (status, removed value)
//
// one item at a time; remove steps through pop and resp, insert into an empty
// queue or a rejected item goes to resp, other inserts shift once per moved entry
// one write port on the entry ram moves one entry per cycle during insert
// reset clears head, count and output valid; ram contents need no clearing
// a stalled result holds the block after the next item has been taken
// ---------------------------------------------------------------------------
module stable_priority_queue_top #(
	parameter int QUEUE_DEPTH = spq_pkg::QUEUE_DEPTH_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  spq_pkg::in_item_t  in_data,
	output logic               out_valid,
	input  logic               out_stall,
	output spq_pkg::out_item_t out_data
);

	spq_pkg::cmd_t  cmd;
	spq_pkg::stat_t stat;

	// sequencer
	spq_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_op    (in_data.operation),
		.in_stall (in_stall),
		.stat     (stat),
		.cmd      (cmd)
	);

	// storage and results
	spq_dpath #(
		.QUEUE_DEPTH (QUEUE_DEPTH)
	) u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_data   (in_data),
		.cmd       (cmd),
		.stat      (stat),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);

endmodule

>>> design/spq_ram.sv
// ---------------------------------------------------------------------------
// spq_ram
// generic simple dual port ram, one write port, one registered read port
// ---------------------------------------------------------------------------
module spq_ram #(
	parameter int WIDTH = spq_pkg::ENTRY_W,
	parameter int DEPTH = spq_pkg::QUEUE_DEPTH_DEF
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	// write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

>>> design/spq_ctrl.sv
// ---------------------------------------------------------------------------
// spq_ctrl
// sequencer for insert and remove; steps the datapath through each item
// ---------------------------------------------------------------------------
module spq_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	input  spq_pkg::op_t   in_op,
	output logic           in_stall,
	input  spq_pkg::stat_t stat,
	output spq_pkg::cmd_t  cmd
);

	spq_pkg::state_t state_q;
	spq_pkg::state_t state_d;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= spq_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state and commands
	always_comb begin
		state_d           = state_q;
		in_stall          = 1'b1;
		cmd.capture       = 1'b0;
		cmd.rd_sel        = spq_pkg::RD_NONE;
		cmd.wr_sel        = spq_pkg::WR_NONE;
		cmd.cnt_inc       = 1'b0;
		cmd.pop_head      = 1'b0;
		cmd.res_set       = 1'b0;
		cmd.res_status    = spq_pkg::STAT_INSERTED;
		cmd.res_take_data = 1'b0;
		cmd.out_load      = 1'b0;
		unique case (state_q)
			spq_pkg::S_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					cmd.capture = 1'b1;
					if (in_op == spq_pkg::OP_INSERT) begin
						if (stat.full) begin
							cmd.res_set    = 1'b1;
							cmd.res_status = spq_pkg::STAT_FULL;
							state_d        = spq_pkg::S_RESP;
						end else if (stat.empty) begin
							// nothing to pass: write straight to the head
							cmd.wr_sel     = spq_pkg::WR_NEW_TAIL;
							cmd.cnt_inc    = 1'b1;
							cmd.res_set    = 1'b1;
							cmd.res_status = spq_pkg::STAT_INSERTED;
							state_d        = spq_pkg::S_RESP;
						end else begin
							cmd.rd_sel = spq_pkg::RD_TAIL;
							state_d    = spq_pkg::S_SHIFT;
						end
					end else begin
						if (stat.empty) begin
							cmd.res_set    = 1'b1;
							cmd.res_status = spq_pkg::STAT_EMPTY;
							state_d        = spq_pkg::S_RESP;
						end else begin
							cmd.rd_sel = spq_pkg::RD_HEAD;
							state_d    = spq_pkg::S_POP;
						end
					end
				end
			end
			spq_pkg::S_POP: begin
				cmd.res_set       = 1'b1;
				cmd.res_status    = spq_pkg::STAT_REMOVED;
				cmd.res_take_data = 1'b1;
				cmd.pop_head      = 1'b1;
				state_d           = spq_pkg::S_RESP;
			end
			spq_pkg::S_SHIFT: begin
				if (stat.shift_gt) begin
					// move the larger entry up one slot and, unless at slot zero, look one lower
					cmd.wr_sel = spq_pkg::WR_DATA_UP;
					if (stat.j_zero) begin
						state_d = spq_pkg::S_PLACE;
					end else begin
						cmd.rd_sel = spq_pkg::RD_BELOW;
					end
				end else begin
					cmd.wr_sel     = spq_pkg::WR_NEW_UP;
					cmd.cnt_inc    = 1'b1;
					cmd.res_set    = 1'b1;
					cmd.res_status = spq_pkg::STAT_INSERTED;
					state_d        = spq_pkg::S_RESP;
				end
			end
			spq_pkg::S_PLACE: begin
				cmd.wr_sel     = spq_pkg::WR_NEW_AT;
				cmd.cnt_inc    = 1'b1;
				cmd.res_set    = 1'b1;
				cmd.res_status = spq_pkg::STAT_INSERTED;
				state_d        = spq_pkg::S_RESP;
			end
			spq_pkg::S_RESP: begin
				if (stat.out_free) begin
					cmd.out_load = 1'b1;
					state_d      = spq_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = spq_pkg::S_IDLE;
			end
		endcase
	end

endmodule

>>> design/spq_dpath.sv
// ---------------------------------------------------------------------------
// spq_dpath
// ring buffer of sorted entries, head and count, result and output registers
// ---------------------------------------------------------------------------
module spq_dpath #(
	parameter int QUEUE_DEPTH = spq_pkg::QUEUE_DEPTH_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  spq_pkg::in_item_t in_data,
	input  spq_pkg::cmd_t     cmd,
	output spq_pkg::stat_t    stat,
	output logic              out_valid,
	input  logic              out_stall,
	output spq_pkg::out_item_t out_data
);

	localparam int AW   = $clog2(QUEUE_DEPTH);
	localparam int RING = 2 ** AW;
	localparam int CW   = $clog2(QUEUE_DEPTH + 1);
	localparam logic [CW-1:0] DEPTH_C = CW'(QUEUE_DEPTH);

	logic [AW-1:0] head_q;
	logic [CW-1:0] count_q;
	logic [AW-1:0] j_q;
	spq_pkg::entry_t new_q;
	spq_pkg::status_t res_status_q;
	logic signed [spq_pkg::VALUE_W-1:0] res_value_q;
	logic out_valid_q;
	spq_pkg::out_item_t out_data_q;

	logic [AW-1:0] count_lo;
	logic rd_en;
	logic [AW-1:0] rd_addr;
	logic wr_en;
	logic [AW-1:0] wr_addr;
	spq_pkg::entry_t wr_data;
	spq_pkg::entry_t rd_data;
	spq_pkg::entry_t in_entry;

	assign count_lo       = count_q[AW-1:0];
	assign in_entry.prio  = in_data.item_priority;
	assign in_entry.value = in_data.item_value;

	// read address: logical slot plus head, wraps around the ring
	always_comb begin
		rd_en   = 1'b1;
		rd_addr = head_q;
		case (cmd.rd_sel)
			spq_pkg::RD_TAIL:  rd_addr = head_q + count_lo - AW'(1);
			spq_pkg::RD_HEAD:  rd_addr = head_q;
			spq_pkg::RD_BELOW: rd_addr = head_q + j_q - AW'(1);
			default:           rd_en   = 1'b0;
		endcase
	end

	// write address and data
	always_comb begin
		wr_en   = 1'b1;
		wr_addr = head_q + j_q + AW'(1);
		wr_data = new_q;
		case (cmd.wr_sel)
			spq_pkg::WR_DATA_UP: wr_data = rd_data;
			spq_pkg::WR_NEW_UP:  wr_data = new_q;
			spq_pkg::WR_NEW_AT:  wr_addr = head_q + j_q;
			spq_pkg::WR_NEW_TAIL: begin
				wr_addr = head_q + count_lo;
				wr_data = in_entry;
			end
			default: wr_en = 1'b0;
		endcase
	end

	spq_ram #(
		.WIDTH (spq_pkg::ENTRY_W),
		.DEPTH (RING)
	) u_ram (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	// status to the controller
	assign stat.full     = (count_q == DEPTH_C);
	assign stat.empty    = (count_q == '0);
	assign stat.j_zero   = (j_q == '0);
	assign stat.shift_gt = (rd_data.prio > new_q.prio);
	assign stat.out_free = !out_valid_q || !out_stall;

	// head, count and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q      <= '0;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.cnt_inc) begin
				count_q <= count_q + CW'(1);
			end else if (cmd.pop_head) begin
				count_q <= count_q - CW'(1);
				head_q  <= head_q + AW'(1);
			end
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// scan index, new entry, result and output payload
	always_ff @(posedge clk) begin
		if (cmd.rd_sel == spq_pkg::RD_TAIL) begin
			j_q <= count_lo - AW'(1);
		end else if (cmd.rd_sel == spq_pkg::RD_BELOW) begin
			j_q <= j_q - AW'(1);
		end
		if (cmd.capture) begin
			new_q <= in_entry;
		end
		if (cmd.res_set) begin
			res_status_q <= cmd.res_status;
			res_value_q  <= cmd.res_take_data ? rd_data.value : '0;
		end
		if (cmd.out_load) begin
			out_data_q.status        <= res_status_q;
			out_data_q.removed_value <= res_value_q;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

endmodule

>>> design/spq_checker.sv
// ---------------------------------------------------------------------------
// spq_checker
// port-level checks of the priority queue, tracks occupancy from results
// ---------------------------------------------------------------------------
`include "stable_priority_queue_top_defines.svh"

module spq_checker #(
	parameter int QUEUE_DEPTH = spq_pkg::QUEUE_DEPTH_DEF
) (
	input logic               clk,
	input logic               arst_n,
	input logic               in_valid,
	input logic               in_stall,
	input spq_pkg::in_item_t  in_data,
	input logic               out_valid,
	input logic               out_stall,
	input spq_pkg::out_item_t out_data
);

	localparam int CW = $clog2(QUEUE_DEPTH + 1);
	localparam logic [CW-1:0] DEPTH_C = CW'(QUEUE_DEPTH);

	logic [CW-1:0] occ_q;
	logic          out_xfer;

	assign out_xfer = out_valid && !out_stall;

	// occupancy as seen from delivered results
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q <= '0;
		end else if (out_xfer) begin
			if (out_data.status == spq_pkg::STAT_INSERTED) begin
				occ_q <= occ_q + CW'(1);
			end else if (out_data.status == spq_pkg::STAT_REMOVED) begin
				occ_q <= occ_q - CW'(1);
			end
		end
	end

	`SPQ_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_data), "stalled result changed")
	`SPQ_ASSERT_NOW(a_zero_value, out_valid && (out_data.status != spq_pkg::STAT_REMOVED), out_data.removed_value == '0, "removed value not zero")
	`SPQ_ASSERT_NOW(a_empty_occ, out_xfer && (out_data.status == spq_pkg::STAT_EMPTY), occ_q == '0, "empty reported with entries stored")
	`SPQ_ASSERT_NOW(a_full_occ, out_xfer && (out_data.status == spq_pkg::STAT_FULL), occ_q == DEPTH_C, "full reported below depth")

endmodule

bind stable_priority_queue_top spq_checker #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_spq_checker (.*);

>>> tb/stable_priority_queue_top_tb.sv
// ---------------------------------------------------------------------------
// stable_priority_queue_top_tb
// checks the priority queue result by result against its own sorted list;
// short directed run over the field extremes, ties and the empty case,
// then random fill, drain and mixed episodes with random gaps and stalls
// ---------------------------------------------------------------------------
module stable_priority_queue_top_tb;
	import spq_pkg::*;

	localparam int DEPTH       = QUEUE_DEPTH_DEF;
	localparam int RAND_ITEMS  = 600;
	localparam int IDLE_PCT    = 34;
	localparam int CALM_FIRST  = 250;
	localparam int CALM_LAST   = 400;
	localparam int DRAIN_WAIT  = 4 * DEPTH + 20;
	localparam int STUCK_LIMIT = 4000;
	localparam int REPORT_MAX  = 10;

	// sorted entry list and the results it predicts
	class spq_scoreboard;
		entry_t    sorted_entries[$];
		out_item_t pending_results[$];
		int        failures;

		function new();
			failures = 0;
		endfunction

		// work out the result of one accepted input transfer
		function void note_input(in_item_t it);
			out_item_t res;
			entry_t    e;
			int        pos;
			res.removed_value = '0;
			if (it.operation == OP_INSERT) begin
				if (sorted_entries.size() >= DEPTH) begin
					res.status = STAT_FULL;
				end else begin
					// new entry goes behind every entry of lower or equal priority
					pos = 0;
					while (pos < sorted_entries.size() &&
						sorted_entries[pos].prio <= it.item_priority)
						pos++;
					e.prio  = it.item_priority;
					e.value = it.item_value;
					sorted_entries.insert(pos, e);
					res.status = STAT_INSERTED;
				end
			end else begin
				if (sorted_entries.size() == 0) begin
					res.status = STAT_EMPTY;
				end else begin
					e = sorted_entries.pop_front();
					res.status        = STAT_REMOVED;
					res.removed_value = e.value;
				end
			end
			pending_results.push_back(res);
		endfunction

		// compare one output transfer with the oldest prediction
		function void check_result(out_item_t got);
			out_item_t want;
			if (pending_results.size() == 0) begin
				failures++;
				if (failures <= REPORT_MAX)
					$display("unexpected result: status %0d value %0d",
						got.status, got.removed_value);
				return;
			end
			want = pending_results.pop_front();
			if (got.status !== want.status || got.removed_value !== want.removed_value) begin
				failures++;
				if (failures <= REPORT_MAX)
					$display("mismatch: status exp %0d got %0d, value exp %0d got %0d",
						want.status, got.status, want.removed_value, got.removed_value);
			end
		endfunction

		function int pending_count();
			return pending_results.size();
		endfunction
	endclass

	logic      clk;
	logic      arst_n;
	logic      in_valid;
	logic      in_stall;
	in_item_t  in_data;
	logic      out_valid;
	logic      out_stall;
	out_item_t out_data;

	spq_scoreboard sb;
	bit            calm;
	int            items_sent;
	int            stuck_cycles;

	stable_priority_queue_top #(
		.QUEUE_DEPTH(DEPTH)
	) uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.in_data  (in_data),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_data (out_data)
	);

	// clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// receiver stalls at random, except in the calm stretch
	always @(negedge clk) begin
		out_stall <= !calm && ($urandom_range(0, 99) < IDLE_PCT);
	end

	// transfer monitor and watchdog
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_stall)
				sb.note_input(in_data);
			if (out_valid && !out_stall)
				sb.check_result(out_data);
			if ((in_valid && !in_stall) || (out_valid && !out_stall))
				stuck_cycles = 0;
			else
				stuck_cycles++;
			if (stuck_cycles >= STUCK_LIMIT) begin
				$display("[stable_priority_queue_top] ERROR");
				$finish;
			end
		end
	end

	// present one item and hold it until the transfer happens
	task automatic send_item(in_item_t it);
		bit done;
		while (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= it;
		done = 1'b0;
		while (!done) begin
			@(posedge clk);
			done = !in_stall;
			@(negedge clk);
		end
		items_sent++;
		calm = (items_sent >= CALM_FIRST && items_sent < CALM_LAST);
	endtask

	task automatic send_insert(logic signed [VALUE_W-1:0] v, logic signed [PRIO_W-1:0] p);
		in_item_t it;
		it.operation     = OP_INSERT;
		it.item_value    = v;
		it.item_priority = p;
		send_item(it);
	endtask

	// remove with junk in the ignored fields
	task automatic send_remove();
		in_item_t it;
		it.operation     = OP_REMOVE;
		it.item_value    = $urandom();
		it.item_priority = PRIO_W'($urandom());
		send_item(it);
	endtask

	// random item; insert_pct sets the mix, ties come from a narrow priority band
	function automatic in_item_t make_item(int insert_pct);
		in_item_t it;
		int       band;
		it.operation  = ($urandom_range(0, 99) < insert_pct) ? OP_INSERT : OP_REMOVE;
		it.item_value = $urandom();
		if ($urandom_range(0, 19) == 0)
			it.item_value = $urandom_range(0, 1) ? 32'sh7fff_ffff : 32'sh8000_0000;
		if ($urandom_range(0, 1)) begin
			band = $urandom_range(0, 8);
			it.item_priority = PRIO_W'(band - 4);
		end else begin
			it.item_priority = PRIO_W'($urandom());
		end
		return it;
	endfunction

	initial begin
		in_item_t it;
		int       mix;
		int       run_len;
		sb           = new();
		calm         = 1'b0;
		items_sent   = 0;
		stuck_cycles = 0;
		in_valid     = 1'b0;
		in_data      = '0;
		out_stall    = 1'b0;
		arst_n       = 1'b0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// remove from an empty queue
		send_remove();
		// field extremes and equal priorities
		send_insert(32'sh7fff_ffff, 16'sh7fff);
		send_insert(32'sh8000_0000, 16'sh8000);
		send_insert(32'sh0000_0000, 16'sh0000);
		send_insert(32'shffff_ffff, 16'sh0000);
		send_insert(32'sh0000_0001, 16'sh0000);
		send_insert(32'sh5555_5555, 16'shffff);
		send_insert(32'shaaaa_aaaa, 16'sh0001);
		send_insert(32'sh1234_5678, 16'sh7fff);
		// drain in priority order, then one past empty
		repeat (9) send_remove();

		// random episodes: filling, draining, mixed
		while (items_sent < RAND_ITEMS) begin
			case ($urandom_range(0, 9))
				0, 1, 2, 3: mix = 85;
				4, 5, 6:    mix = 15;
				default:    mix = 50;
			endcase
			run_len = $urandom_range(10, 40);
			repeat (run_len) begin
				it = make_item(mix);
				send_item(it);
			end
		end
		in_valid <= 1'b0;

		// wait for every result, then let the block settle
		while (sb.pending_count() != 0)
			@(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);

		if (sb.failures == 0 && sb.pending_count() == 0) begin
			$display("[stable_priority_queue_top] OK");
		end else begin
			$display("[stable_priority_queue_top] ERROR");
		end
		$finish;
	end

endmodule
